@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files of the sorted set engine.
// Needs nothing else; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SUS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SUS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/sus_pkg.sv @@
// Package of the sorted unique set engine: widths, command codes, FSM states
// and the command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package sus_pkg;

	localparam int unsigned CAPACITY_DEF = 64;
	localparam int unsigned VAL_W        = 32;
	localparam int unsigned IDX_W        = 6;
	localparam int unsigned CNT_OUT_W    = 7;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_FIND   = 2'd1,
		CMD_RANGE  = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH,
		ST_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_INS_WR,
		ST_ELEM_RD,
		ST_ELEM_CAP,
		ST_DONE
	} state_t;

	// Actions the controller asks of the datapath in one cycle.
	typedef struct packed {
		logic load;
		logic srch_rd;
		logic srch_cmp;
		logic upper_init;
		logic save_first;
		logic save_end;
		logic set_full;
		logic shift_init;
		logic shift_rd;
		logic shift_wr;
		logic ins_wr;
		logic elem_rd;
		logic elem_cap;
		logic out_load;
	} dp_cmd_t;

	// Conditions the datapath reports back to the controller.
	typedef struct packed {
		cmd_t cmd;
		logic lo_lt_hi;
		logic upper_pass;
		logic found;
		logic store_full;
		logic shift_empty;
		logic shift_last;
	} dp_stat_t;

endpackage

@@ rtl/sus_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Uses sus_pkg for its default width and depth.
`timescale 1ns / 1ps

module sus_ram import sus_pkg::*; #(
	parameter int unsigned WIDTH = VAL_W,
	parameter int unsigned DEPTH = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/sus_ctrl.sv @@
// Controller of the sorted unique set engine: the sequencing state machine and
// the output valid flag. Depends on sus_pkg.
`timescale 1ns / 1ps

module sus_ctrl import sus_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  cmd_t     in_cmd,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  dcmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output valid: set when a result is loaded, cleared when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dcmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// Next state and datapath commands.
	always_comb begin
		state_d  = state_q;
		dcmd     = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					dcmd.load = 1'b1;
					state_d   = (in_cmd == CMD_READ) ? ST_ELEM_RD : ST_SRCH;
				end
			end
			ST_SRCH: begin
				if (stat.lo_lt_hi) begin
					dcmd.srch_rd = 1'b1;
					state_d      = ST_CMP;
				end else begin
					case (stat.cmd)
						CMD_RANGE: begin
							if (!stat.upper_pass) begin
								dcmd.save_first = 1'b1;
								dcmd.upper_init = 1'b1;
							end else begin
								dcmd.save_end = 1'b1;
								state_d       = ST_DONE;
							end
						end
						CMD_INSERT: begin
							if (stat.found) begin
								state_d = ST_DONE;
							end else if (stat.store_full) begin
								dcmd.set_full = 1'b1;
								state_d       = ST_DONE;
							end else begin
								dcmd.shift_init = 1'b1;
								state_d = stat.shift_empty ? ST_INS_WR : ST_SHIFT_RD;
							end
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_CMP: begin
				dcmd.srch_cmp = 1'b1;
				state_d       = ST_SRCH;
			end
			ST_SHIFT_RD: begin
				dcmd.shift_rd = 1'b1;
				state_d       = ST_SHIFT_WR;
			end
			ST_SHIFT_WR: begin
				dcmd.shift_wr = 1'b1;
				state_d       = stat.shift_last ? ST_INS_WR : ST_SHIFT_RD;
			end
			ST_INS_WR: begin
				dcmd.ins_wr = 1'b1;
				state_d     = ST_DONE;
			end
			ST_ELEM_RD: begin
				dcmd.elem_rd = 1'b1;
				state_d      = ST_ELEM_CAP;
			end
			ST_ELEM_CAP: begin
				dcmd.elem_cap = 1'b1;
				state_d       = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					dcmd.out_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/sus_dp.sv @@
// Datapath of the sorted unique set engine: element RAM, binary search bounds,
// shift pointer, stored count and result registers. Depends on sus_pkg and sus_ram.
`timescale 1ns / 1ps

module sus_dp import sus_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 dcmd,
	output dp_stat_t                stat,
	input  cmd_t                    in_cmd,
	input  logic signed [VAL_W-1:0] in_value,
	input  logic signed [VAL_W-1:0] in_upper,
	input  logic [IDX_W-1:0]        in_index,
	output logic                    found,
	output logic                    inserted,
	output logic                    full_flag,
	output logic [CNT_OUT_W-1:0]    first_index,
	output logic [CNT_OUT_W-1:0]    end_index,
	output logic [CNT_OUT_W-1:0]    count,
	output logic signed [VAL_W-1:0] element
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned XW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
	localparam int unsigned XI = (CW > IDX_W) ? CW : IDX_W;

	// Item registers.
	cmd_t                    cmd_q;
	logic signed [VAL_W-1:0] val_q;
	logic signed [VAL_W-1:0] upv_q;
	logic [IDX_W-1:0]        idx_q;

	// Search and shift registers.
	logic signed [VAL_W-1:0] key_q;
	logic                    incl_q;
	logic [CW-1:0]           lo_q;
	logic [CW-1:0]           hi_q;
	logic [CW-1:0]           mid_q;
	logic [CW-1:0]           j_q;
	logic [CW-1:0]           count_q;

	// Per-item results.
	logic                    found_q;
	logic                    ins_q;
	logic                    full_q;
	logic [CW-1:0]           first_q;
	logic [CW-1:0]           end_q;
	logic signed [VAL_W-1:0] elem_q;

	// Output registers.
	logic                    o_found_q;
	logic                    o_ins_q;
	logic                    o_full_q;
	logic [CNT_OUT_W-1:0]    o_first_q;
	logic [CNT_OUT_W-1:0]    o_end_q;
	logic [CNT_OUT_W-1:0]    o_count_q;
	logic signed [VAL_W-1:0] o_elem_q;

	// RAM interface.
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [VAL_W-1:0] ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [VAL_W-1:0] ram_rdata;

	logic [CW:0]             mid_sum;
	logic [CW-1:0]           mid_w;
	logic [CW-1:0]           jm1;
	logic [XI-1:0]           idx_x;
	logic [XI-1:0]           cnt_xi;
	logic                    elem_ok;
	logic signed [VAL_W-1:0] rd_s;
	logic                    rd_lt;
	logic                    rd_eq;
	logic [XW-1:0]           first_x;
	logic [XW-1:0]           end_x;
	logic [XW-1:0]           count_x;

	sus_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Midpoint of the open search interval and other derived indexes.
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_w   = mid_sum[CW:1];
	assign jm1     = j_q - 1'b1;
	assign idx_x   = XI'(idx_q);
	assign cnt_xi  = XI'(count_q);
	assign elem_ok = idx_x < cnt_xi;

	// Compare of the probed element against the search key.
	assign rd_s  = $signed(ram_rdata);
	assign rd_lt = rd_s < key_q;
	assign rd_eq = rd_s == key_q;

	// RAM address and write selection.
	always_comb begin
		ram_raddr = mid_w[AW-1:0];
		if (dcmd.shift_rd) begin
			ram_raddr = jm1[AW-1:0];
		end else if (dcmd.elem_rd) begin
			ram_raddr = idx_x[AW-1:0];
		end
		ram_we    = dcmd.shift_wr | dcmd.ins_wr;
		ram_waddr = dcmd.ins_wr ? lo_q[AW-1:0] : j_q[AW-1:0];
		ram_wdata = dcmd.ins_wr ? val_q : ram_rdata;
	end

	// Stored count, the only register of the datapath that is reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (dcmd.ins_wr) begin
			count_q <= CW'(count_q + 1'b1);
		end
	end

	// Item capture, binary search, shift pointer and per-item results.
	always_ff @(posedge clk) begin
		if (dcmd.load) begin
			cmd_q   <= in_cmd;
			val_q   <= in_value;
			upv_q   <= in_upper;
			idx_q   <= in_index;
			key_q   <= in_value;
			incl_q  <= 1'b0;
			lo_q    <= '0;
			hi_q    <= count_q;
			found_q <= 1'b0;
			ins_q   <= 1'b0;
			full_q  <= 1'b0;
			first_q <= '0;
			end_q   <= '0;
			elem_q  <= '0;
		end
		if (dcmd.srch_rd) begin
			mid_q <= mid_w;
		end
		if (dcmd.srch_cmp) begin
			if (rd_lt || (incl_q && rd_eq)) begin
				lo_q <= CW'(mid_q + 1'b1);
			end else begin
				hi_q <= mid_q;
			end
			if (rd_eq && !incl_q && cmd_q != CMD_RANGE) begin
				found_q <= 1'b1;
			end
		end
		if (dcmd.save_first) begin
			first_q <= lo_q;
		end
		if (dcmd.upper_init) begin
			key_q  <= upv_q;
			incl_q <= 1'b1;
			lo_q   <= '0;
			hi_q   <= count_q;
		end
		if (dcmd.save_end) begin
			end_q <= lo_q;
		end
		if (dcmd.set_full) begin
			full_q <= 1'b1;
		end
		if (dcmd.shift_init) begin
			j_q <= count_q;
		end
		if (dcmd.shift_wr) begin
			j_q <= jm1;
		end
		if (dcmd.ins_wr) begin
			ins_q <= 1'b1;
		end
		if (dcmd.elem_cap) begin
			elem_q <= elem_ok ? rd_s : '0;
		end
	end

	// Result register; the count already includes an insert of this item.
	assign first_x = XW'(first_q);
	assign end_x   = XW'(end_q);
	assign count_x = XW'(count_q);

	always_ff @(posedge clk) begin
		if (dcmd.out_load) begin
			o_found_q <= found_q;
			o_ins_q   <= ins_q;
			o_full_q  <= full_q;
			o_first_q <= first_x[CNT_OUT_W-1:0];
			o_end_q   <= end_x[CNT_OUT_W-1:0];
			o_count_q <= count_x[CNT_OUT_W-1:0];
			o_elem_q  <= elem_q;
		end
	end

	assign found       = o_found_q;
	assign inserted    = o_ins_q;
	assign full_flag   = o_full_q;
	assign first_index = o_first_q;
	assign end_index   = o_end_q;
	assign count       = o_count_q;
	assign element     = o_elem_q;

	// Status back to the controller.
	assign stat.cmd         = cmd_q;
	assign stat.lo_lt_hi    = lo_q < hi_q;
	assign stat.upper_pass  = incl_q;
	assign stat.found       = found_q;
	assign stat.store_full  = count_q == CW'(CAPACITY);
	assign stat.shift_empty = count_q == lo_q;
	assign stat.shift_last  = j_q == CW'(lo_q + 1'b1);

endmodule

@@ rtl/sorted_unique_set_engine.sv @@
// Sorted unique set engine, top level. One item at a time; a search probe of the single-read
// RAM reads the midpoint and then compares it, and a search takes at most p = ceil(log2(count+1))
// probes. A find runs one search, a range runs a search for each bound, a read fetches the indexed
// element; an insert searches and, unless present or dropped, moves larger elements up and writes.
// The next item is taken the cycle after the result is loaded into the output register.
// Reset (arst_n, asynchronous) clears the count; RAM contents are undefined, no clear pass.
`timescale 1ns / 1ps

module sorted_unique_set_engine import sus_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              command,
	input  logic signed [VAL_W-1:0] value,
	input  logic signed [VAL_W-1:0] upper_value,
	input  logic [IDX_W-1:0]        index,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    found,
	output logic                    inserted,
	output logic                    full_flag,
	output logic [CNT_OUT_W-1:0]    first_index,
	output logic [CNT_OUT_W-1:0]    end_index,
	output logic [CNT_OUT_W-1:0]    count,
	output logic signed [VAL_W-1:0] element
);

	dp_cmd_t  dcmd;
	dp_stat_t stat;
	cmd_t     in_cmd;

	assign in_cmd = cmd_t'(command);

	// Sequencer.
	sus_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_cmd   (in_cmd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.dcmd     (dcmd)
	);

	// Storage, search and result datapath.
	sus_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.dcmd       (dcmd),
		.stat       (stat),
		.in_cmd     (in_cmd),
		.in_value   (value),
		.in_upper   (upper_value),
		.in_index   (index),
		.found      (found),
		.inserted   (inserted),
		.full_flag  (full_flag),
		.first_index(first_index),
		.end_index  (end_index),
		.count      (count),
		.element    (element)
	);

endmodule

@@ rtl/sus_checker.sv @@
// Port-level checker for the sorted unique set engine, bound to the top level.
// Depends on assert_macros.svh and sus_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sus_checker import sus_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic                    found,
	input logic                    inserted,
	input logic                    full_flag,
	input logic [CNT_OUT_W-1:0]    first_index,
	input logic [CNT_OUT_W-1:0]    end_index,
	input logic [CNT_OUT_W-1:0]    count,
	input logic signed [VAL_W-1:0] element
);

	logic [CNT_OUT_W-1:0] prev_count_q;
	logic                 in_beat;
	logic                 out_beat;
	logic                 out_stall;
	logic                 outcome_ok;
	logic [CNT_OUT_W-1:0] count_want;
	logic                 bounds_ok;
	logic [3*CNT_OUT_W+VAL_W+2:0] res_bits;

	// Count reported by the last result beat; the store starts empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_count_q <= '0;
		end else if (out_valid && out_ready) begin
			prev_count_q <= count;
		end
	end

	// Handshake terms and the expected relations between result fields.
	assign in_beat    = in_valid && in_ready;
	assign out_beat   = out_valid && out_ready;
	assign out_stall  = out_valid && !out_ready;
	assign outcome_ok = $onehot0({found, inserted, full_flag});
	assign count_want = CNT_OUT_W'(prev_count_q + CNT_OUT_W'(inserted));
	assign bounds_ok  = (first_index <= count) && (end_index <= count);
	assign res_bits   = {found, inserted, full_flag, first_index, end_index, count, element};

	// An insert outcome is at most one of present, added or dropped.
	`SUS_ASSERT_IMP(a_outcome_onehot, clk, arst_n, out_valid, outcome_ok, "insert outcome not one-hot")

	// The count only moves by one successful insert per result.
	`SUS_ASSERT_IMP(a_count_chain, clk, arst_n, out_beat, count == count_want, "count skipped")

	// Range bounds never point past the end of the store.
	`SUS_ASSERT_IMP(a_bounds_in_store, clk, arst_n, out_valid, bounds_ok, "range bound beyond count")

	// A stalled result beat holds its payload.
	`SUS_ASSERT_NXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(res_bits), "beat changed")

	// Only one item is in flight: after an accepted beat the input is closed.
	`SUS_ASSERT_NXT(a_one_in_flight, clk, arst_n, in_beat, !in_ready, "second beat taken too early")

endmodule

bind sorted_unique_set_engine sus_checker u_sus_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.found      (found),
	.inserted   (inserted),
	.full_flag  (full_flag),
	.first_index(first_index),
	.end_index  (end_index),
	.count      (count),
	.element    (element)
);
